/* sv/mpr_pkg.sv */
// Shared types and constants for the median-edge pixel reconstruction block.
package mpr_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 13;
  localparam int PIX_W      = 8;
  localparam int SAMPLE_W   = 16;
  localparam int QSH_W      = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(352);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(288);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SHIFT  = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    PH_ROW   = 2'd0,
    PH_COL   = 2'd1,
    PH_INNER = 2'd2
  } phase_t;

  // Position and frame-end flag of one transaction.
  typedef struct packed {
    phase_t             phase;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               done;
  } pos_t;

endpackage

/* sv/mpr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/mpr_ctrl.sv */
// Frame sequencer: phase and row/column counters, advanced once per accepted transaction.
module mpr_ctrl
  import mpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [DIM_W-1:0] frame_width,
  input  logic [DIM_W-1:0] frame_height,
  output pos_t             cur_pos
);

  phase_t           phase_r, phase_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  // Saturate the frame size to 1 .. MAX, expressed as the last index.
  always_comb begin
    if (frame_width == '0) begin
      col_last = '0;
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(frame_width - DIM_W'(1));
    end
    if (frame_height == '0) begin
      row_last = '0;
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(frame_height - DIM_W'(1));
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cur_pos.phase = phase_r;
    cur_pos.row   = row_r;
    cur_pos.col   = col_r;
    cur_pos.done  = 1'b0;
    case (phase_r)
      PH_ROW: begin
        cur_pos.row = '0;
        if (col_r >= col_last) begin
          if (row_last == '0) begin
            cur_pos.done = 1'b1;
            row_nxt      = '0;
            col_nxt      = '0;
          end else begin
            phase_nxt = PH_COL;
            row_nxt   = ROW_W'(1);
            col_nxt   = '0;
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      PH_COL: begin
        cur_pos.col = '0;
        if (row_r >= row_last) begin
          if (col_last == '0) begin
            cur_pos.done = 1'b1;
            phase_nxt    = PH_ROW;
            row_nxt      = '0;
            col_nxt      = '0;
          end else begin
            phase_nxt = PH_INNER;
            row_nxt   = ROW_W'(1);
            col_nxt   = COL_W'(1);
          end
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end
      PH_INNER: begin
        if (col_r >= col_last) begin
          if (row_r >= row_last) begin
            cur_pos.done = 1'b1;
            phase_nxt    = PH_ROW;
            row_nxt      = '0;
            col_nxt      = '0;
          end else begin
            row_nxt = row_r + ROW_W'(1);
            col_nxt = COL_W'(1);
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      default: begin
        phase_nxt = PH_ROW;
        row_nxt   = '0;
        col_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ROW;
      row_r   <= '0;
      col_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

/* sv/mpr_recon.sv */
// Median-edge prediction, scaled residual add and clamp at zero for one pixel; edge phases pass the sample through.
module mpr_recon
  import mpr_pkg::*;
(
  input  phase_t                     phase,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [QSH_W-1:0]           quant_shift,
  input  logic [PIX_W-1:0]           left,
  input  logic [PIX_W-1:0]           upper,
  input  logic [PIX_W-1:0]           upper_left,
  output logic [PIX_W-1:0]           pixel
);

  localparam int SH_W  = SAMPLE_W + (1 << QSH_W) - 1;
  localparam int SUM_W = SH_W + 1;

  logic [PIX_W-1:0]        hi, lo, pred;
  logic [PIX_W:0]          grad;
  logic signed [SH_W-1:0]  resid_sh;
  logic signed [SUM_W-1:0] val;

  always_comb begin
    hi   = (left > upper) ? left : upper;
    lo   = (left > upper) ? upper : left;
    grad = {1'b0, left} + {1'b0, upper} - {1'b0, upper_left};
    if (upper_left >= hi) begin
      pred = lo;
    end else if (upper_left <= lo) begin
      pred = hi;
    end else begin
      pred = grad[PIX_W-1:0];
    end
  end

  assign resid_sh = SH_W'(sample) <<< quant_shift;
  assign val      = SUM_W'(resid_sh) + $signed({{(SUM_W-PIX_W){1'b0}}, pred});

  always_comb begin
    case (phase)
      PH_INNER: pixel = val[SUM_W-1] ? '0 : val[PIX_W-1:0];
      default:  pixel = sample[PIX_W-1:0];
    endcase
  end

endmodule

/* sv/med_predictive_pixel_reconstruct_core.sv */
// Top level of the median-edge predictive pixel reconstruction block.
//
// Usage:
// - Input channel (in_valid / in_ready / in_sample_value): one transaction per
//   pixel. Each frame sends row 0 as raw bytes, then column 0 of rows 1 onward
//   as raw bytes, then signed residuals of the interior pixels in raster order.
// - Output channel (out_valid / out_ready / out_pixel_*): exactly one
//   transaction per input transaction, in order, with row and column, and
//   out_frame_done set on the last pixel of the frame.
// - Configuration port (cfg_wr_en / cfg_index / cfg_data): frame width, frame
//   height and quantization shift; write only while no transaction is pending.
// Timing: two register stages. Accepting a transaction issues the line-store
//   and first-column-store reads; the next stage predicts and reconstructs,
//   writes the stores and loads the output register. out_valid rises once the
//   middle stage advances into the output register; while out_ready stays high,
//   throughput is one pixel per cycle, set by the single read and single
//   write port of each store.
// Reset: counters return to row 0 column 0 of the first row phase, both stages
//   empty, configuration to 352 x 288 with no shift. Store contents are not
//   cleared; every entry is written in a frame before it is read.
// Stall: when out_ready is low the output register holds and the middle stage
//   fills; in_ready drops only when both are full.
module med_predictive_pixel_reconstruct_core
  import mpr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [PIX_W-1:0]           out_pixel_value,
  output logic [ROW_W-1:0]           out_pixel_row,
  output logic [COL_W-1:0]           out_pixel_col,
  output logic                       out_frame_done,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [DIM_W-1:0]           cfg_data
);

  // Configuration registers.
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic [QSH_W-1:0] quant_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
      quant_shift_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        CFG_QUANT_SHIFT:  quant_shift_r  <= cfg_data[QSH_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control.
  logic s1_v_r;
  logic s1_fire;
  logic accept;

  assign s1_fire  = s1_v_r && (!out_valid || out_ready);
  assign in_ready = !s1_v_r || s1_fire;
  assign accept   = in_valid && in_ready;

  // Sequencer gives the position of the transaction being accepted.
  pos_t cur_pos;

  mpr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .cur_pos      (cur_pos)
  );

  // Middle stage: sample and position wait here for the store read data.
  pos_t                       s1_pos_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r    <= cur_pos;
      s1_sample_r <= in_sample_value;
    end
  end

  // Stores. Writes happen as the middle stage advances.
  logic             up_wr_en, fc_wr_en;
  logic [PIX_W-1:0] pix;
  logic [PIX_W-1:0] up_q, fc_q;

  assign up_wr_en = s1_fire && (s1_pos_r.phase == PH_ROW || s1_pos_r.phase == PH_INNER);
  assign fc_wr_en = s1_fire && (s1_pos_r.phase == PH_COL ||
                                (s1_pos_r.phase == PH_ROW && s1_pos_r.col == '0));

  mpr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_row (
    .clk     (clk),
    .wr_en   (up_wr_en),
    .wr_addr (s1_pos_r.col),
    .wr_data (pix),
    .rd_en   (accept),
    .rd_addr (cur_pos.col),
    .rd_data (up_q)
  );

  mpr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_HEIGHT)) u_first_col (
    .clk     (clk),
    .wr_en   (fc_wr_en),
    .wr_addr (s1_pos_r.row),
    .wr_data (pix),
    .rd_en   (accept),
    .rd_addr (cur_pos.row),
    .rd_data (fc_q)
  );

  // Bypass: a write landing on the read address at the same edge is
  // forwarded, since the store read returns the old contents. This covers
  // narrow frames where the same column or row comes back immediately.
  logic             up_hit_r, fc_hit_r;
  logic [PIX_W-1:0] up_byp_r, fc_byp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_hit_r <= 1'b0;
      fc_hit_r <= 1'b0;
    end else if (accept) begin
      up_hit_r <= up_wr_en && (s1_pos_r.col == cur_pos.col);
      fc_hit_r <= fc_wr_en && (s1_pos_r.row == cur_pos.row);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      up_byp_r <= pix;
      fc_byp_r <= pix;
    end
  end

  // Neighbor registers. Column 0 of the previous row is kept in a register,
  // so the first-column store needs only one read per pixel.
  logic [PIX_W-1:0] left_r, upleft_r, col0_prev_r;
  logic [PIX_W-1:0] nb_up, nb_fc, nb_left, nb_upleft;
  logic             first_inner;

  assign nb_up       = up_hit_r ? up_byp_r : up_q;
  assign nb_fc       = fc_hit_r ? fc_byp_r : fc_q;
  assign first_inner = (s1_pos_r.col == COL_W'(1));
  assign nb_left     = first_inner ? nb_fc : left_r;
  assign nb_upleft   = first_inner ? col0_prev_r : upleft_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      upleft_r    <= '0;
      col0_prev_r <= '0;
    end else if (s1_fire) begin
      if (s1_pos_r.phase == PH_INNER) begin
        left_r   <= pix;
        upleft_r <= nb_up;
        if (first_inner) begin
          col0_prev_r <= nb_left;
        end
      end else if (s1_pos_r.phase == PH_ROW && s1_pos_r.col == '0) begin
        col0_prev_r <= pix;
      end
    end
  end

  mpr_recon u_recon (
    .phase       (s1_pos_r.phase),
    .sample      (s1_sample_r),
    .quant_shift (quant_shift_r),
    .left        (nb_left),
    .upper       (nb_up),
    .upper_left  (nb_upleft),
    .pixel       (pix)
  );

  // Output register: load on advance, drop valid once taken.
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pix_r  <= pix;
      out_row_r  <= s1_pos_r.row;
      out_col_r  <= s1_pos_r.col;
      out_done_r <= s1_pos_r.done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pix_r;
  assign out_pixel_row   = out_row_r;
  assign out_pixel_col   = out_col_r;
  assign out_frame_done  = out_done_r;

  // The middle stage is never overwritten while it still holds a pixel.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_v_r) |-> s1_fire)
    else $error("middle stage overwritten");

  // The end of a frame restarts the sequencer at the first row, column 0.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cur_pos.done) |=> (cur_pos.phase == PH_ROW && cur_pos.col == '0))
    else $error("sequencer did not restart after frame end");

  // Interior pixels never sit in column 0 or row 0.
  a_inner_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_pos_r.phase == PH_INNER) |-> (s1_pos_r.col != '0 && s1_pos_r.row != '0))
    else $error("interior pixel on frame edge");

  // The output register is loaded exactly when the middle stage advances.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("advanced pixel not presented");

endmodule
